/* rtl/isu_pkg.sv */
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants for the indexed sequence store: list capacity,
// field widths, operation codes and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int USED_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_MODIFY = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    logic load;        // capture request
    logic rd_pos;      // read entry at position
    logic rd_shift;    // read neighbor of index
    logic wr_append;   // write value at count
    logic wr_pos;      // write value at position
    logic wr_shift;    // write read data at index
    logic idx_step;    // advance index
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_ok;
    logic cap_rd;      // capture read data for result
    logic res_load;    // load result register
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic not_full;
    logic ins_last;
    logic del_none;
    logic del_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/isu_ctrl.sv */
// ----------------------------------------------------------------------------
// isu_ctrl
// Request sequencer: decodes the captured operation, steps the shift loop
// for insert and delete, and hands the finished beat to the result register.
// ----------------------------------------------------------------------------
module isu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  isu_pkg::status_t status,
  output isu_pkg::cmd_t    cmd,
  output logic             idle
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_SH_RD   = 7'b0000100,
    S_SH_WR   = 7'b0001000,
    S_FIN_WR  = 7'b0010000,
    S_RD_WAIT = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (status.op)
          isu_pkg::OP_APPEND: begin
            if (status.not_full) begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
              cmd.set_ok    = 1'b1;
            end
          end
          isu_pkg::OP_INSERT: begin
            if (status.not_full && status.in_range) begin
              state_next = S_SH_RD;
            end
          end
          isu_pkg::OP_DELETE: begin
            if (status.in_range) begin
              if (status.del_none) begin
                cmd.cnt_dec = 1'b1;
                cmd.set_ok  = 1'b1;
              end else begin
                state_next = S_SH_RD;
              end
            end
          end
          isu_pkg::OP_MODIFY: begin
            if (status.in_range) begin
              cmd.wr_pos = 1'b1;
              cmd.set_ok = 1'b1;
            end
          end
          isu_pkg::OP_READ: begin
            if (status.in_range) begin
              cmd.rd_pos = 1'b1;
              state_next = S_RD_WAIT;
            end
          end
          isu_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.set_ok  = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        cmd.rd_shift = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_step = 1'b1;
        state_next   = S_SH_RD;
        if (status.op == isu_pkg::OP_INSERT) begin
          if (status.ins_last) begin
            state_next = S_FIN_WR;
          end
        end else if (status.del_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_FIN_WR: begin
        cmd.wr_pos  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_DONE;
      end
      S_RD_WAIT: begin
        cmd.cap_rd = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/isu_dpath.sv */
// ----------------------------------------------------------------------------
// isu_dpath
// Entry memory, count, request and index registers, and the output result
// register with its valid/stall handshake.
// ----------------------------------------------------------------------------
module isu_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  isu_pkg::cmd_t                      cmd,
  output isu_pkg::status_t                   status,
  input  logic [isu_pkg::OP_W-1:0]           operation,
  input  logic [isu_pkg::POS_W-1:0]          position,
  input  logic signed [isu_pkg::DATA_W-1:0]  entry_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [isu_pkg::DATA_W-1:0]  read_data,
  output logic [isu_pkg::USED_W-1:0]         used_count,
  output logic                               accepted
);

  localparam int CMP_W = isu_pkg::CNT_W + 1;

  logic [isu_pkg::DATA_W-1:0] mem [isu_pkg::CAPACITY];
  logic [isu_pkg::DATA_W-1:0] rdata;

  isu_pkg::op_t               op;
  logic [isu_pkg::POS_W-1:0]  pos;
  logic [isu_pkg::DATA_W-1:0] val;
  logic [isu_pkg::ADDR_W-1:0] idx;
  logic [isu_pkg::CNT_W-1:0]  cnt;
  logic                       ok;
  logic [isu_pkg::DATA_W-1:0] rd_hold;

  logic                       wr_en;
  logic [isu_pkg::ADDR_W-1:0] wr_addr;
  logic [isu_pkg::DATA_W-1:0] wr_data;
  logic                       rd_en;
  logic [isu_pkg::ADDR_W-1:0] rd_addr;
  logic [isu_pkg::ADDR_W-1:0] pos_addr;
  logic [isu_pkg::ADDR_W-1:0] idx_dn;
  logic [isu_pkg::ADDR_W-1:0] idx_up;
  logic [CMP_W-1:0]           pos_x;
  logic [CMP_W-1:0]           idx_x;
  logic [CMP_W-1:0]           cnt_x;

  assign pos_addr = isu_pkg::ADDR_W'(pos);
  assign idx_dn   = idx - 1'b1;
  assign idx_up   = idx + 1'b1;
  assign pos_x    = CMP_W'(pos);
  assign idx_x    = CMP_W'(idx);
  assign cnt_x    = CMP_W'(cnt);

  assign status.op       = op;
  assign status.in_range = pos_x < cnt_x;
  assign status.not_full = cnt_x < CMP_W'(isu_pkg::CAPACITY);
  assign status.ins_last = idx_dn == pos_addr;
  assign status.del_none = (idx_x + CMP_W'(1)) >= cnt_x;
  assign status.del_last = (idx_x + CMP_W'(2)) >= cnt_x;
  assign status.out_free = !out_valid || !out_stall;

  // memory ports
  assign wr_en   = cmd.wr_append || cmd.wr_pos || cmd.wr_shift;
  assign wr_data = cmd.wr_shift ? rdata : val;
  assign rd_en   = cmd.rd_pos || cmd.rd_shift;

  always_comb begin
    priority if (cmd.wr_append) begin
      wr_addr = cnt[isu_pkg::ADDR_W-1:0];
    end else if (cmd.wr_shift) begin
      wr_addr = idx;
    end else begin
      wr_addr = pos_addr;
    end
  end

  always_comb begin
    priority if (cmd.rd_pos) begin
      rd_addr = pos_addr;
    end else if (op == isu_pkg::OP_INSERT) begin
      rd_addr = idx_dn;
    end else begin
      rd_addr = idx_up;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // request and index registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= isu_pkg::op_t'(operation);
      pos <= position;
      val <= entry_value;
      if (isu_pkg::op_t'(operation) == isu_pkg::OP_INSERT) begin
        idx <= cnt[isu_pkg::ADDR_W-1:0];
      end else begin
        idx <= isu_pkg::ADDR_W'(position);
      end
    end else if (cmd.idx_step) begin
      idx <= (op == isu_pkg::OP_INSERT) ? idx_dn : idx_up;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok      <= 1'b0;
      rd_hold <= '0;
    end else begin
      if (cmd.set_ok) begin
        ok <= 1'b1;
      end
      if (cmd.cap_rd) begin
        rd_hold <= rdata;
      end
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      read_data  <= rd_hold;
      used_count <= isu_pkg::USED_W'(cnt);
      accepted   <= ok;
    end
  end

endmodule

/* rtl/indexed_sequence_store_unit.sv */
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// Ordered list of signed 32-bit entries with append, insert, delete, modify,
// read and clear. Insert and delete move entries one at a time through a
// single-port-write, single-port-read memory.
// ----------------------------------------------------------------------------
// Append, modify, clear and any refused request finish in the execute state;
// read adds a read-wait state; insert and delete run the shift loop (read,
// write) once per moved entry, and insert ends with a final write.
// One request at a time; the next request is taken the cycle after the
// result is loaded.
// Reset (synchronous, rst high) empties the list and drops any pending result.
module indexed_sequence_store_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [isu_pkg::OP_W-1:0]           operation,
  input  logic [isu_pkg::POS_W-1:0]          position,
  input  logic signed [isu_pkg::DATA_W-1:0]  entry_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [isu_pkg::DATA_W-1:0]  read_data,
  output logic [isu_pkg::USED_W-1:0]         used_count,
  output logic                               accepted
);

  isu_pkg::cmd_t    cmd;
  isu_pkg::status_t status;
  logic             idle;

  assign in_stall = !idle;

  isu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  isu_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (operation),
    .position    (position),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .used_count  (used_count),
    .accepted    (accepted)
  );

endmodule

/* rtl/isu_checker.sv */
// ----------------------------------------------------------------------------
// isu_checker
// Port-level checks for the indexed sequence store, bound to the top level.
// ----------------------------------------------------------------------------
module isu_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [isu_pkg::OP_W-1:0]           operation,
  input logic [isu_pkg::POS_W-1:0]          position,
  input logic signed [isu_pkg::DATA_W-1:0]  entry_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [isu_pkg::DATA_W-1:0]  read_data,
  input logic [isu_pkg::USED_W-1:0]         used_count,
  input logic                               accepted
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(used_count) <= isu_pkg::CAPACITY))
    else $error("used_count above capacity");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (read_data == '0))
    else $error("refused request returned nonzero data");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind indexed_sequence_store_unit isu_checker u_isu_checker (.*);
